### hdl/battery_level_from_adc_top_defines.svh
// Assertion macros for the one file that checks its own logic.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef BATTERY_LEVEL_FROM_ADC_TOP_DEFINES_SVH
`define BATTERY_LEVEL_FROM_ADC_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/blfa_pkg.sv
`timescale 1ns / 1ps

package blfa_pkg;

	// Field widths.
	localparam int unsigned RAW_W     = 13;
	localparam int unsigned VOLT_W    = 13;
	localparam int unsigned LEVEL_W   = 14;
	localparam int unsigned MV_W      = 14;
	localparam int unsigned CFG_W     = 14;
	localparam int unsigned CFG_IDX_W = 3;

	// Shared multiplier and divider widths.
	localparam int unsigned MUL_W     = 16;
	localparam int unsigned PROD_W    = 2 * MUL_W;
	localparam int unsigned DIV_N_W   = 28;
	localparam int unsigned DIV_D_W   = 13;
	localparam int unsigned DIV_Q_W   = 15;
	localparam int unsigned DIV_CNT_W = 4;

	localparam logic [LEVEL_W-1:0]      LEVEL_MAX   = 14'd10000;
	localparam logic signed [MUL_W-1:0] ADC_SCALE   = 16'sd4000;
	// Reciprocal of five: floor(x*MV_RECIP >> MV_RECIP_SH) is floor(x/5)
	// for every x below 43690.
	localparam logic signed [MUL_W-1:0] MV_RECIP    = 16'sd26215;
	localparam int unsigned             MV_RECIP_SH = 17;
	localparam logic signed [15:0]      MV_SAT_MAX  = 16'sd8191;
	localparam logic signed [15:0]      MV_SAT_MIN  = -16'sd8192;

	// Register reset values.
	localparam logic [VOLT_W-1:0]  FULL_V_RST  = 13'd4200;
	localparam logic [VOLT_W-1:0]  KNEE1_V_RST = 13'd3660;
	localparam logic [LEVEL_W-1:0] KNEE1_L_RST = 14'd5000;
	localparam logic [VOLT_W-1:0]  KNEE2_V_RST = 13'd3600;
	localparam logic [LEVEL_W-1:0] KNEE2_L_RST = 14'd2100;
	localparam logic [VOLT_W-1:0]  KNEE3_V_RST = 13'd3560;
	localparam logic [LEVEL_W-1:0] KNEE3_L_RST = 14'd1000;
	localparam logic [VOLT_W-1:0]  EMPTY_V_RST = 13'd3100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_V  = 3'd0,
		REG_KNEE1_V = 3'd1,
		REG_KNEE1_L = 3'd2,
		REG_KNEE2_V = 3'd3,
		REG_KNEE2_L = 3'd4,
		REG_KNEE3_V = 3'd5,
		REG_KNEE3_L = 3'd6,
		REG_EMPTY_V = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_RAW,
		S_SCALE,
		S_MUL_MV,
		S_LOAD_MV,
		S_TOP_CHECK,
		S_WALK,
		S_MUL_SLOPE,
		S_DIV_GO,
		S_DIV_SLOPE
	} fsm_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_N_W-1:0]   dividend;
		logic [DIV_D_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_Q_W-1:0]   quotient;
	} div_rsp_t;

	// Clamps a signed level to the range 0..LEVEL_MAX.
	function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [16:0] v);
		logic [LEVEL_W-1:0] r;
		if (v < 0) begin
			r = '0;
		end else if (v > $signed({3'b000, LEVEL_MAX})) begin
			r = LEVEL_MAX;
		end else begin
			r = v[LEVEL_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/blfa_mul.sv
`timescale 1ns / 1ps

// Signed multiplier with a registered product.
module blfa_mul (
	input  logic                                    clk,
	input  logic signed [blfa_pkg::MUL_W-1:0]       a,
	input  logic signed [blfa_pkg::MUL_W-1:0]       b,
	output logic signed [blfa_pkg::PROD_W-1:0]      prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

### hdl/blfa_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The dividend must be below
// the divisor shifted left by the quotient width.
module blfa_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  blfa_pkg::div_req_t   req,
	output blfa_pkg::div_rsp_t   rsp
);

	localparam int unsigned DSH_W = blfa_pkg::DIV_D_W + blfa_pkg::DIV_Q_W - 1;

	logic [blfa_pkg::DIV_N_W-1:0]   rem_q;
	logic [DSH_W-1:0]               dsh_q;
	logic [blfa_pkg::DIV_Q_W-1:0]   quo_q;
	logic [blfa_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           run_q;
	logic                           done_q;
	logic                           fits;

	assign fits = rem_q >= blfa_pkg::DIV_N_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= blfa_pkg::DIV_CNT_W'(blfa_pkg::DIV_Q_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == blfa_pkg::DIV_CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend;
			dsh_q <= {req.divisor, {(blfa_pkg::DIV_Q_W-1){1'b0}}};
			quo_q <= '0;
		end else if (run_q) begin
			if (fits) begin
				rem_q <= rem_q - blfa_pkg::DIV_N_W'(dsh_q);
			end
			quo_q <= {quo_q[blfa_pkg::DIV_Q_W-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

### hdl/battery_level_from_adc_top.sv
`timescale 1ns / 1ps

// Battery voltage and remaining charge from one ADC sample. A transaction
// starts at a rising edge where start is high and busy is low. The sample is
// scaled to millivolts (2*600*(raw*4000 >>> ADC_BITS)/1000, truncated toward
// zero, saturated to 14 bits signed) and then looked up on a five-point
// discharge curve whose voltages and middle levels come from the eight
// configuration registers. The result on battery_mv and level_pptt is
// marked by done, high for exactly one cycle, and the receiver cannot stall
// it, so capture it in that cycle. A transaction ends at the top check when
// the voltage is at or above the top point; otherwise the curve walk visits
// one to four points and then either ends or goes on to interpolate. done
// rises in the same cycle that busy falls, and a new start is taken in that
// same cycle. The cost is set by the one shared restoring divider, which
// delivers one quotient bit per cycle and is used only for the interpolation,
// and by the curve walk, which checks one point per cycle. The millivolt
// scaling uses the shared multiplier twice, once for the ADC scale and once
// for a reciprocal multiply by one fifth. Configuration is written through
// cfg_wen, cfg_index and cfg_data and must only be written while busy is
// low.
module battery_level_from_adc_top #(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [blfa_pkg::RAW_W-1:0]     raw_sample,
	output logic                                  done,
	output logic signed [blfa_pkg::MV_W-1:0]      battery_mv,
	output logic        [blfa_pkg::LEVEL_W-1:0]   level_pptt,
	input  logic                                  cfg_wen,
	input  logic        [blfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [blfa_pkg::CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [blfa_pkg::VOLT_W-1:0]  full_v_q, knee1_v_q, knee2_v_q, knee3_v_q, empty_v_q;
	logic [blfa_pkg::LEVEL_W-1:0] knee1_l_q, knee2_l_q, knee3_l_q;

	// Sequencer and datapath registers.
	blfa_pkg::fsm_state_t state_q, state_d;
	logic [2:0]                            idx_q;
	logic                                  done_q;
	logic signed [blfa_pkg::MUL_W-1:0]     mul_a_q, mul_b_q;
	logic signed [blfa_pkg::MV_W-1:0]      mv_q;
	logic [blfa_pkg::DIV_D_W-1:0]          span_q;
	logic                                  neg_q;
	logic [blfa_pkg::LEVEL_W-1:0]          level_q;

	// Shared units.
	logic signed [blfa_pkg::PROD_W-1:0]    prod;
	blfa_pkg::div_req_t                    div_req;
	blfa_pkg::div_rsp_t                    div_rsp;

	// Datapath wires.
	logic signed [blfa_pkg::PROD_W-1:0]    prod_shr;
	logic signed [15:0]                    q_s;
	logic signed [15:0]                    q_neg;
	logic signed [15:0]                    q_mag;
	logic [blfa_pkg::PROD_W-blfa_pkg::MV_RECIP_SH-1:0] fifth;
	logic [15:0]                           mv_mag;
	logic signed [blfa_pkg::PROD_W-1:0]    prod_neg;
	logic [blfa_pkg::DIV_N_W-1:0]          prod_mag;
	logic signed [15:0]                    mv_wide;
	logic signed [blfa_pkg::MV_W-1:0]      mv_sat;
	logic signed [14:0]                    mv_ext;
	logic [blfa_pkg::VOLT_W-1:0]           volt_cur, volt_prev;
	logic [blfa_pkg::LEVEL_W-1:0]          lvl_cur, lvl_prev;
	logic signed [14:0]                    volt_cur_s;
	logic signed [14:0]                    dl_s, dv_s;
	logic [blfa_pkg::VOLT_W-1:0]           span_d;
	logic                                  at_top, mv_lt_cur, walk_more, span_zero;
	logic signed [16:0]                    sq_s, res_s;

	// Sequencer outputs.
	logic                                  ld_raw, ld_scale, ld_slope, ld_mv, ld_neg;
	logic                                  set_idx1, idx_inc;
	logic                                  fin;
	logic [blfa_pkg::LEVEL_W-1:0]          fin_level;

	// ------------------------------------------------------------------
	// Configuration port. Indexes cover all eight registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_v_q  <= blfa_pkg::FULL_V_RST;
			knee1_v_q <= blfa_pkg::KNEE1_V_RST;
			knee1_l_q <= blfa_pkg::KNEE1_L_RST;
			knee2_v_q <= blfa_pkg::KNEE2_V_RST;
			knee2_l_q <= blfa_pkg::KNEE2_L_RST;
			knee3_v_q <= blfa_pkg::KNEE3_V_RST;
			knee3_l_q <= blfa_pkg::KNEE3_L_RST;
			empty_v_q <= blfa_pkg::EMPTY_V_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				blfa_pkg::REG_FULL_V:  full_v_q  <= cfg_data[blfa_pkg::VOLT_W-1:0];
				blfa_pkg::REG_KNEE1_V: knee1_v_q <= cfg_data[blfa_pkg::VOLT_W-1:0];
				blfa_pkg::REG_KNEE1_L: knee1_l_q <= cfg_data;
				blfa_pkg::REG_KNEE2_V: knee2_v_q <= cfg_data[blfa_pkg::VOLT_W-1:0];
				blfa_pkg::REG_KNEE2_L: knee2_l_q <= cfg_data;
				blfa_pkg::REG_KNEE3_V: knee3_v_q <= cfg_data[blfa_pkg::VOLT_W-1:0];
				blfa_pkg::REG_KNEE3_L: knee3_l_q <= cfg_data;
				blfa_pkg::REG_EMPTY_V: empty_v_q <= cfg_data[blfa_pkg::VOLT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Shared multiplier and divider.
	// ------------------------------------------------------------------
	blfa_mul u_mul (
		.clk    (clk),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.prod_q (prod)
	);

	blfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ------------------------------------------------------------------
	// Voltage scaling. The shifted product is the floor of raw*4000 over
	// 2**ADC_BITS. Six fifths of it, truncated toward zero, is the magnitude
	// plus a fifth of the magnitude, with the sign put back afterwards. The
	// fifth comes from the multiplier, which holds the magnitude on its first
	// operand while it forms the reciprocal product.
	// ------------------------------------------------------------------
	always_comb begin
		prod_shr = prod >>> ADC_BITS;
		q_s      = prod_shr[15:0];
		q_neg    = -q_s;
		q_mag    = q_s[15] ? q_neg : q_s;

		prod_neg = -prod;
		prod_mag = prod[blfa_pkg::PROD_W-1] ? prod_neg[blfa_pkg::DIV_N_W-1:0]
		                                    : prod[blfa_pkg::DIV_N_W-1:0];

		fifth   = prod[blfa_pkg::PROD_W-1:blfa_pkg::MV_RECIP_SH];
		mv_mag  = $unsigned(mul_a_q) + {1'b0, fifth};
		mv_wide = neg_q ? -$signed(mv_mag) : $signed(mv_mag);
		if (mv_wide < blfa_pkg::MV_SAT_MIN) begin
			mv_sat = blfa_pkg::MV_SAT_MIN[blfa_pkg::MV_W-1:0];
		end else if (mv_wide > blfa_pkg::MV_SAT_MAX) begin
			mv_sat = blfa_pkg::MV_SAT_MAX[blfa_pkg::MV_W-1:0];
		end else begin
			mv_sat = mv_wide[blfa_pkg::MV_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Curve points. Point 0 is the full point at LEVEL_MAX and point 4 is
	// the empty point at level zero.
	// ------------------------------------------------------------------
	always_comb begin
		case (idx_q)
			3'd1: begin
				volt_cur  = knee1_v_q;
				lvl_cur   = knee1_l_q;
				volt_prev = full_v_q;
				lvl_prev  = blfa_pkg::LEVEL_MAX;
			end
			3'd2: begin
				volt_cur  = knee2_v_q;
				lvl_cur   = knee2_l_q;
				volt_prev = knee1_v_q;
				lvl_prev  = knee1_l_q;
			end
			3'd3: begin
				volt_cur  = knee3_v_q;
				lvl_cur   = knee3_l_q;
				volt_prev = knee2_v_q;
				lvl_prev  = knee2_l_q;
			end
			3'd4: begin
				volt_cur  = empty_v_q;
				lvl_cur   = '0;
				volt_prev = knee3_v_q;
				lvl_prev  = knee3_l_q;
			end
			default: begin
				volt_cur  = full_v_q;
				lvl_cur   = blfa_pkg::LEVEL_MAX;
				volt_prev = full_v_q;
				lvl_prev  = blfa_pkg::LEVEL_MAX;
			end
		endcase
	end

	// Walk and interpolation terms. When interpolating, the battery voltage
	// lies at or above the current point and below the previous one, so the
	// span is positive and the quotient stays below the level difference.
	always_comb begin
		mv_ext     = {mv_q[blfa_pkg::MV_W-1], mv_q};
		volt_cur_s = $signed({2'b00, volt_cur});
		at_top     = mv_ext >= $signed({2'b00, full_v_q});
		mv_lt_cur  = mv_ext < volt_cur_s;
		walk_more  = (idx_q < 3'd4) && mv_lt_cur;
		span_zero  = volt_prev == volt_cur;
		span_d     = volt_prev - volt_cur;
		dl_s       = $signed({1'b0, lvl_prev}) - $signed({1'b0, lvl_cur});
		dv_s       = mv_ext - volt_cur_s;
		sq_s       = neg_q ? -$signed({2'b00, div_rsp.quotient})
		                   : $signed({2'b00, div_rsp.quotient});
		res_s      = $signed({3'b000, lvl_cur}) + sq_s;
	end

	// ------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			blfa_pkg::S_IDLE: begin
				if (start) begin
					state_d = blfa_pkg::S_MUL_RAW;
				end
			end
			blfa_pkg::S_MUL_RAW:   state_d = blfa_pkg::S_SCALE;
			blfa_pkg::S_SCALE:     state_d = blfa_pkg::S_MUL_MV;
			blfa_pkg::S_MUL_MV:    state_d = blfa_pkg::S_LOAD_MV;
			blfa_pkg::S_LOAD_MV:   state_d = blfa_pkg::S_TOP_CHECK;
			blfa_pkg::S_TOP_CHECK: begin
				state_d = at_top ? blfa_pkg::S_IDLE : blfa_pkg::S_WALK;
			end
			blfa_pkg::S_WALK: begin
				if (walk_more) begin
					state_d = blfa_pkg::S_WALK;
				end else if (mv_lt_cur || span_zero) begin
					state_d = blfa_pkg::S_IDLE;
				end else begin
					state_d = blfa_pkg::S_MUL_SLOPE;
				end
			end
			blfa_pkg::S_MUL_SLOPE: state_d = blfa_pkg::S_DIV_GO;
			blfa_pkg::S_DIV_GO:    state_d = blfa_pkg::S_DIV_SLOPE;
			blfa_pkg::S_DIV_SLOPE: begin
				if (div_rsp.done) begin
					state_d = blfa_pkg::S_IDLE;
				end
			end
			default: state_d = blfa_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs.
	// ------------------------------------------------------------------
	always_comb begin
		ld_raw           = 1'b0;
		ld_scale         = 1'b0;
		ld_slope         = 1'b0;
		ld_mv            = 1'b0;
		ld_neg           = 1'b0;
		set_idx1         = 1'b0;
		idx_inc          = 1'b0;
		fin              = 1'b0;
		fin_level        = '0;
		div_req.start    = 1'b0;
		div_req.dividend = prod_mag;
		div_req.divisor  = span_q;
		unique case (state_q)
			blfa_pkg::S_IDLE: begin
				ld_raw = start;
			end
			blfa_pkg::S_SCALE: begin
				ld_neg   = 1'b1;
				ld_scale = 1'b1;
			end
			blfa_pkg::S_LOAD_MV: begin
				ld_mv = 1'b1;
			end
			blfa_pkg::S_TOP_CHECK: begin
				set_idx1  = 1'b1;
				fin       = at_top;
				fin_level = blfa_pkg::LEVEL_MAX;
			end
			blfa_pkg::S_WALK: begin
				if (walk_more) begin
					idx_inc = 1'b1;
				end else if (mv_lt_cur || span_zero) begin
					fin       = 1'b1;
					fin_level = blfa_pkg::clamp_level($signed({3'b000, lvl_cur}));
				end else begin
					ld_slope = 1'b1;
				end
			end
			blfa_pkg::S_DIV_GO: begin
				ld_neg        = 1'b1;
				div_req.start = 1'b1;
			end
			blfa_pkg::S_DIV_SLOPE: begin
				fin       = div_rsp.done;
				fin_level = blfa_pkg::clamp_level(res_s);
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer and control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= blfa_pkg::S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (set_idx1) begin
				idx_q <= 3'd1;
			end else if (idx_inc) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (ld_raw) begin
			mul_a_q <= blfa_pkg::MUL_W'(raw_sample);
			mul_b_q <= blfa_pkg::ADC_SCALE;
		end else if (ld_scale) begin
			mul_a_q <= q_mag;
			mul_b_q <= blfa_pkg::MV_RECIP;
		end else if (ld_slope) begin
			mul_a_q <= {dl_s[14], dl_s};
			mul_b_q <= {dv_s[14], dv_s};
			span_q  <= span_d;
		end
		if (ld_neg) begin
			neg_q <= (state_q == blfa_pkg::S_SCALE) ? q_s[15]
			                                         : prod[blfa_pkg::PROD_W-1];
		end
		if (ld_mv) begin
			mv_q <= mv_sat;
		end
		if (fin) begin
			level_q <= fin_level;
		end
	end

	assign busy       = state_q != blfa_pkg::S_IDLE;
	assign done       = done_q;
	assign battery_mv = mv_q;
	assign level_pptt = level_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`include "battery_level_from_adc_top_defines.svh"

	`BLFA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while a transaction is in progress")
	`BLFA_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted transaction did not raise busy")
	`BLFA_ASSERT_NOW(a_level_range, done, level_pptt <= blfa_pkg::LEVEL_MAX, "level out of range")
	`BLFA_ASSERT_NOW(a_div_owner, div_rsp.done, state_q == blfa_pkg::S_DIV_SLOPE, "divider finished outside the interpolation step")

endmodule

### bench/battery_level_checker.sv
`timescale 1ns / 1ps

// Watches the sample and configuration ports of the battery level block,
// predicts each reading from a private copy of the curve registers and
// compares it with what the block reports.
module battery_level_checker #(
	parameter int unsigned ADC_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic                                  busy,
	input  logic signed [blfa_pkg::RAW_W-1:0]     raw_sample,
	input  logic                                  done,
	input  logic signed [blfa_pkg::MV_W-1:0]      battery_mv,
	input  logic        [blfa_pkg::LEVEL_W-1:0]   level_pptt,
	input  logic                                  cfg_wen,
	input  logic        [blfa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [blfa_pkg::CFG_W-1:0]     cfg_data,
	output int                                    fail_count,
	output int                                    pending
);
	import blfa_pkg::*;

	typedef struct packed {
		logic signed [MV_W-1:0] mv;
		logic [LEVEL_W-1:0]     level;
	} reading_t;

	// Curve points from the top (full) to the bottom (empty) point.
	logic [VOLT_W-1:0]  point_mv [5];
	logic [LEVEL_W-1:0] knee_level [1:3];
	reading_t           expected_readings [$];

	function automatic reading_t predict_reading(input logic signed [RAW_W-1:0] raw);
		longint   scaled;
		longint   mv;
		longint   lvl;
		longint   span;
		longint   volt [5];
		longint   lvls [5];
		int       i;
		reading_t r;
		scaled = longint'(raw) * 4000;
		mv = ((scaled >>> ADC_BITS) * 1200) / 1000;
		if (mv < longint'(MV_SAT_MIN)) begin
			mv = longint'(MV_SAT_MIN);
		end
		if (mv > longint'(MV_SAT_MAX)) begin
			mv = longint'(MV_SAT_MAX);
		end
		for (i = 0; i < 5; i++) begin
			volt[i] = longint'(point_mv[i]);
		end
		lvls[0] = longint'(LEVEL_MAX);
		for (i = 1; i < 4; i++) begin
			lvls[i] = longint'(knee_level[i]);
		end
		lvls[4] = 0;
		if (mv >= volt[0]) begin
			lvl = longint'(LEVEL_MAX);
		end else begin
			// Walk down to the first point at or below the voltage, stopping at the empty point.
			i = 1;
			while (i < 4 && mv < volt[i]) begin
				i++;
			end
			if (mv < volt[i]) begin
				lvl = lvls[i];
			end else begin
				span = volt[i-1] - volt[i];
				if (span == 0) begin
					lvl = lvls[i];
				end else begin
					lvl = lvls[i] + ((lvls[i-1] - lvls[i]) * (mv - volt[i])) / span;
				end
			end
			if (lvl < 0) begin
				lvl = 0;
			end
			if (lvl > longint'(LEVEL_MAX)) begin
				lvl = longint'(LEVEL_MAX);
			end
		end
		r.mv    = mv[MV_W-1:0];
		r.level = lvl[LEVEL_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		reading_t want;
		int       new_fails;
		if (!arst_n) begin
			point_mv[0]   <= FULL_V_RST;
			point_mv[1]   <= KNEE1_V_RST;
			point_mv[2]   <= KNEE2_V_RST;
			point_mv[3]   <= KNEE3_V_RST;
			point_mv[4]   <= EMPTY_V_RST;
			knee_level[1] <= KNEE1_L_RST;
			knee_level[2] <= KNEE2_L_RST;
			knee_level[3] <= KNEE3_L_RST;
			expected_readings.delete();
			fail_count    <= 0;
			pending       <= 0;
		end else begin
			new_fails = 0;
			if (cfg_wen) begin
				case (cfg_reg_t'(cfg_index))
					REG_FULL_V:  point_mv[0]   <= cfg_data[VOLT_W-1:0];
					REG_KNEE1_V: point_mv[1]   <= cfg_data[VOLT_W-1:0];
					REG_KNEE1_L: knee_level[1] <= cfg_data[LEVEL_W-1:0];
					REG_KNEE2_V: point_mv[2]   <= cfg_data[VOLT_W-1:0];
					REG_KNEE2_L: knee_level[2] <= cfg_data[LEVEL_W-1:0];
					REG_KNEE3_V: point_mv[3]   <= cfg_data[VOLT_W-1:0];
					REG_KNEE3_L: knee_level[3] <= cfg_data[LEVEL_W-1:0];
					REG_EMPTY_V: point_mv[4]   <= cfg_data[VOLT_W-1:0];
					default: begin
					end
				endcase
			end
			if (done) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected result: battery_mv %0d, level_pptt %0d",
						battery_mv, level_pptt);
					new_fails++;
				end else begin
					want = expected_readings.pop_front();
					if (battery_mv !== want.mv) begin
						$error("battery_mv: expected %0d, actual %0d", want.mv, battery_mv);
						new_fails++;
					end
					if (level_pptt !== want.level) begin
						$error("level_pptt: expected %0d, actual %0d", want.level, level_pptt);
						new_fails++;
					end
				end
			end
			if (start && !busy) begin
				expected_readings.push_back(predict_reading(raw_sample));
			end
			fail_count <= fail_count + new_fails;
			pending    <= expected_readings.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

// Top of the bench for the battery level block. This module only produces
// stimulus and announces the verdict; the checker beside the block tracks
// every transaction, predicts the reading and counts the failures.
module testbench;
	import blfa_pkg::*;

	localparam int unsigned ADC_BITS = 12;
	localparam int          PHASES = 8;
	localparam int          SAMPLES_PER_PHASE = 135;

	// Percentage of transactions preceded by an idle gap, one entry per
	// random phase. The result side cannot be stalled, so only the sender
	// idles.
	localparam int IDLE_PCT [PHASES] = '{0, 48, 15, 48, 0, 15, 48, 15};

	// Samples against the reset curve: both ends of the ADC range, around
	// zero, exactly on and one step below the full point, around the first
	// knee, exactly on the second knee, near the third knee, and exactly on
	// and just below the empty point.
	localparam int RESET_CURVE_RAWS [14] = '{
		-4096, -1, 0, 1, 4095, 3584, 3583, 3123, 3124, 3072, 3038, 2647, 2646, 2000
	};

	// Samples against the odd curve below: on and just below the full point
	// (4000 mV), above the out-of-order third knee, on and just below the
	// two knees sharing 3500 mV, deep in the walk, and on and just below the
	// empty point (3000 mV).
	localparam int ODD_CURVE_RAWS [10] = '{
		4095, 3415, 3414, 3160, 2988, 2987, 2900, 2560, 2559, -4096
	};

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [RAW_W-1:0]     raw_sample = '0;
	logic                        done;
	logic signed [MV_W-1:0]      battery_mv;
	logic [LEVEL_W-1:0]          level_pptt;
	logic                        cfg_wen = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_W-1:0]            cfg_data = '0;
	int                          fail_count;
	int                          pending;

	// Shadow of the register values to be loaded into the block next.
	logic [CFG_W-1:0]            curve_regs [8];

	always #4 clk = ~clk;

	battery_level_from_adc_top #(
		.ADC_BITS(ADC_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.raw_sample(raw_sample),
		.done(done),
		.battery_mv(battery_mv),
		.level_pptt(level_pptt),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	battery_level_checker #(
		.ADC_BITS(ADC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.raw_sample(raw_sample),
		.done(done),
		.battery_mv(battery_mv),
		.level_pptt(level_pptt),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Writes all eight registers back to back, one per clock. Only called
	// while the block is idle and start is low.
	task automatic load_curve();
		foreach (curve_regs[i]) begin
			cfg_wen   <= 1'b1;
			cfg_index <= cfg_reg_t'(i);
			cfg_data  <= curve_regs[i];
			@(posedge clk);
		end
		cfg_wen <= 1'b0;
	endtask

	// Drops start and waits until every reading has come back. The checker
	// updates its count at the clock edge, so the task reads the count only
	// after waiting on the clock. A further wait lets the block return to idle.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Offers one sample and returns at the edge where the block takes it.
	// start is left high so that the next sample can follow without a gap.
	task automatic send_sample(input logic signed [RAW_W-1:0] raw, input int idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 45)) @(posedge clk);
		end
		start      <= 1'b1;
		raw_sample <= raw;
		do @(posedge clk); while (busy);
	endtask

	// Every point at the same voltage and every middle level the same.
	function automatic void flat_curve(input int mv, input int lvl);
		curve_regs[REG_FULL_V]  = CFG_W'(mv);
		curve_regs[REG_KNEE1_V] = CFG_W'(mv);
		curve_regs[REG_KNEE1_L] = CFG_W'(lvl);
		curve_regs[REG_KNEE2_V] = CFG_W'(mv);
		curve_regs[REG_KNEE2_L] = CFG_W'(lvl);
		curve_regs[REG_KNEE3_V] = CFG_W'(mv);
		curve_regs[REG_KNEE3_L] = CFG_W'(lvl);
		curve_regs[REG_EMPTY_V] = CFG_W'(mv);
	endfunction

	// A well-formed discharge curve: voltages and levels both fall from the
	// top point to the bottom point.
	function automatic void falling_curve();
		int volts [$];
		int lvls [$];
		repeat (5) volts.push_back($urandom_range(2800, 4600));
		repeat (3) lvls.push_back($urandom_range(1, 10000));
		volts.rsort();
		lvls.rsort();
		curve_regs[REG_FULL_V]  = CFG_W'(volts[0]);
		curve_regs[REG_KNEE1_V] = CFG_W'(volts[1]);
		curve_regs[REG_KNEE1_L] = CFG_W'(lvls[0]);
		curve_regs[REG_KNEE2_V] = CFG_W'(volts[2]);
		curve_regs[REG_KNEE2_L] = CFG_W'(lvls[1]);
		curve_regs[REG_KNEE3_V] = CFG_W'(volts[3]);
		curve_regs[REG_KNEE3_L] = CFG_W'(lvls[2]);
		curve_regs[REG_EMPTY_V] = CFG_W'(volts[4]);
	endfunction

	// Any order and any value the write data can carry. Voltage registers
	// keep only their low 13 bits, so the top data bit is exercised too.
	function automatic void scrambled_curve();
		foreach (curve_regs[i]) begin
			if ($urandom_range(0, 1) == 1) begin
				curve_regs[i] = CFG_W'($urandom_range(0, 16383));
			end else begin
				curve_regs[i] = CFG_W'($urandom_range(0, 4800));
			end
		end
	endfunction

	// Most samples land near one of the curve points, where the walk and the
	// interpolation change; the rest cover the whole ADC range.
	function automatic logic signed [RAW_W-1:0] pick_raw();
		int target_mv;
		int raw;
		if ($urandom_range(0, 99) < 35) begin
			return RAW_W'($urandom_range(0, 8191));
		end
		case ($urandom_range(0, 4))
			0: target_mv = int'(curve_regs[REG_FULL_V][VOLT_W-1:0]);
			1: target_mv = int'(curve_regs[REG_KNEE1_V][VOLT_W-1:0]);
			2: target_mv = int'(curve_regs[REG_KNEE2_V][VOLT_W-1:0]);
			3: target_mv = int'(curve_regs[REG_KNEE3_V][VOLT_W-1:0]);
			default: target_mv = int'(curve_regs[REG_EMPTY_V][VOLT_W-1:0]);
		endcase
		// One ADC step is about 1.17 mV, so scale by 128/150 to get back.
		raw = (target_mv * 128) / 150 + int'($urandom_range(0, 60)) - 30;
		if (raw > 4095) begin
			raw = 4095;
		end
		if (raw < -4096) begin
			raw = -4096;
		end
		return RAW_W'(raw);
	endfunction

	initial begin : stimulus
		// Hold reset at the start, then release it once for the whole run.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed checks on the reset curve. The registers are written with
		// their reset values so that the loaded and predicted states agree
		// either way.
		curve_regs[REG_FULL_V]  = CFG_W'(FULL_V_RST);
		curve_regs[REG_KNEE1_V] = CFG_W'(KNEE1_V_RST);
		curve_regs[REG_KNEE1_L] = KNEE1_L_RST;
		curve_regs[REG_KNEE2_V] = CFG_W'(KNEE2_V_RST);
		curve_regs[REG_KNEE2_L] = KNEE2_L_RST;
		curve_regs[REG_KNEE3_V] = CFG_W'(KNEE3_V_RST);
		curve_regs[REG_KNEE3_L] = KNEE3_L_RST;
		curve_regs[REG_EMPTY_V] = CFG_W'(EMPTY_V_RST);
		load_curve();
		foreach (RESET_CURVE_RAWS[i]) begin
			send_sample(RAW_W'(RESET_CURVE_RAWS[i]), 0);
		end
		settle();

		// An odd curve: the first knee has a level of zero, which must not
		// stop the walk; the second knee shares its voltage with the first
		// and sits above it in level; the third knee lies above the second in
		// voltage, so the walk runs through to the empty point.
		curve_regs[REG_FULL_V]  = CFG_W'(4000);
		curve_regs[REG_KNEE1_V] = CFG_W'(3500);
		curve_regs[REG_KNEE1_L] = CFG_W'(0);
		curve_regs[REG_KNEE2_V] = CFG_W'(3500);
		curve_regs[REG_KNEE2_L] = CFG_W'(3000);
		curve_regs[REG_KNEE3_V] = CFG_W'(3700);
		curve_regs[REG_KNEE3_L] = CFG_W'(9000);
		curve_regs[REG_EMPTY_V] = CFG_W'(3000);
		load_curve();
		foreach (ODD_CURVE_RAWS[i]) begin
			send_sample(RAW_W'(ODD_CURVE_RAWS[i]), 15);
		end
		settle();

		// Random phases, each on its own curve and with its own idling. The
		// first three use the reset curve and the two flat extremes; the rest
		// alternate between well-formed and scrambled curves.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					curve_regs[REG_FULL_V]  = CFG_W'(FULL_V_RST);
					curve_regs[REG_KNEE1_V] = CFG_W'(KNEE1_V_RST);
					curve_regs[REG_KNEE1_L] = KNEE1_L_RST;
					curve_regs[REG_KNEE2_V] = CFG_W'(KNEE2_V_RST);
					curve_regs[REG_KNEE2_L] = KNEE2_L_RST;
					curve_regs[REG_KNEE3_V] = CFG_W'(KNEE3_V_RST);
					curve_regs[REG_KNEE3_L] = KNEE3_L_RST;
					curve_regs[REG_EMPTY_V] = CFG_W'(EMPTY_V_RST);
				end
				1: flat_curve(0, 1);
				2: flat_curve(4800, 10000);
				4, 6: scrambled_curve();
				default: falling_curve();
			endcase
			load_curve();
			for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
				send_sample(pick_raw(), IDLE_PCT[phase]);
			end
			settle();
		end

		// Everything is back; give any stray result time to show up.
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog: the slowest legal run is well under a millisecond.
	initial begin : watchdog
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/blfa_pkg.sv
hdl/blfa_mul.sv
hdl/blfa_div.sv
hdl/battery_level_from_adc_top.sv
bench/battery_level_checker.sv
bench/testbench.sv
